// ===== design/pbwft_pkg.sv =====
// ----------------------------------------------------------------------------
// Protobuf wire field tokenizer package
// Shared types and constants for the parser front, the result queue and the
// output back end.
// ----------------------------------------------------------------------------
`default_nettype none

package pbwft_pkg;

	// Widths of the stream payloads.
	localparam int unsigned S_TDATA_W = 8;
	localparam int unsigned M_TDATA_W = 112;
	localparam int unsigned M_TUSER_W = 3;

	// Result kinds.
	localparam logic [2:0] KIND_VARINT  = 3'd0;
	localparam logic [2:0] KIND_FIXED   = 3'd1;
	localparam logic [2:0] KIND_LENGTH  = 3'd2;
	localparam logic [2:0] KIND_PAYLOAD = 3'd3;
	localparam logic [2:0] KIND_ERROR   = 3'd4;

	// Error codes.
	localparam logic [1:0] ERR_TOO_LONG  = 2'd0;
	localparam logic [1:0] ERR_WIRE_TYPE = 2'd1;
	localparam logic [1:0] ERR_TRUNCATED = 2'd2;

	// Wire types that the parser handles.
	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam logic [2:0] WIRE_FIXED64 = 3'd1;
	localparam logic [2:0] WIRE_LENGTH  = 3'd2;
	localparam logic [2:0] WIRE_FIXED32 = 3'd5;

	// Varint limits: the tenth byte must end the varint.
	localparam logic [3:0] VARINT_LAST_IDX = 4'd9;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_KEY     = 3'd0,
		PH_VALUE   = 3'd1,
		PH_FIXED   = 3'd2,
		PH_LENGTH  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_DRAIN   = 3'd5
	} phase_t;

	// One result word.
	typedef struct packed {
		logic [2:0]  item_kind;
		logic [31:0] field_number;
		logic [2:0]  wire_type;
		logic [63:0] field_value;
		logic [7:0]  payload_value;
		logic [1:0]  error_code;
		logic        buffer_end;
	} result_t;

	// Up to two results caused by one input byte.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} entry_t;

endpackage

`default_nettype wire

// ===== design/pbwft_front.sv =====
// ----------------------------------------------------------------------------
// Protobuf wire field tokenizer front end
// Accepts one buffer byte per cycle while the queue has room, runs the wire
// format parser and turns each byte into a queue entry of 0, 1 or 2 results.
// ----------------------------------------------------------------------------
`default_nettype none

module pbwft_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       data_byte,
	input  wire logic             buffer_last,
	input  wire logic             queue_full,
	output logic                  push,
	output pbwft_pkg::entry_t     entry
);
	import pbwft_pkg::*;

	phase_t      phase_q, phase_d;
	logic [63:0] acc_q, acc_d;
	logic [3:0]  sc_q, sc_d;
	logic [31:0] fnum_q, fnum_d;
	logic [2:0]  wt_q, wt_d;
	logic [63:0] rem_q, rem_d;

	logic        fire;
	logic [6:0]  shift7;
	logic [63:0] acc_or;
	logic        cont;
	logic        too_long;
	logic [63:0] rem_dec;
	logic        key_wt_bad;
	logic        prim_v;
	result_t     prim;
	logic        trunc_v;
	result_t     trunc;

	assign in_ready = !queue_full;
	assign fire     = in_valid && in_ready;

	// Varint absorb: 7 payload bits land at 7 times the byte index.
	assign shift7   = ({3'b000, sc_q} << 3) - {3'b000, sc_q};
	assign acc_or   = acc_q | ({56'd0, 1'b0, data_byte[6:0]} << shift7[5:0]);
	assign cont     = data_byte[7];
	assign too_long = cont && (sc_q == VARINT_LAST_IDX);
	assign rem_dec  = (rem_q != 64'd0) ? (rem_q - 64'd1) : rem_q;

	assign key_wt_bad = !((acc_or[2:0] == WIRE_VARINT) || (acc_or[2:0] == WIRE_FIXED64) ||
		(acc_or[2:0] == WIRE_LENGTH) || (acc_or[2:0] == WIRE_FIXED32));

	// Next parser state.
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		sc_d    = sc_q;
		fnum_d  = fnum_q;
		wt_d    = wt_q;
		rem_d   = rem_q;
		unique case (phase_q)
			PH_KEY, PH_VALUE, PH_LENGTH: begin
				if (too_long) begin
					phase_d = PH_DRAIN;
				end else if (!cont) begin
					acc_d = 64'd0;
					sc_d  = 4'd0;
					if (phase_q == PH_KEY) begin
						fnum_d = acc_or[34:3];
						wt_d   = acc_or[2:0];
						priority if (acc_or[2:0] == WIRE_VARINT) begin
							phase_d = PH_VALUE;
						end else if (acc_or[2:0] == WIRE_FIXED64) begin
							phase_d = PH_FIXED;
							rem_d   = 64'd8;
						end else if (acc_or[2:0] == WIRE_FIXED32) begin
							phase_d = PH_FIXED;
							rem_d   = 64'd4;
						end else if (acc_or[2:0] == WIRE_LENGTH) begin
							phase_d = PH_LENGTH;
						end else begin
							phase_d = PH_DRAIN;
						end
					end else if (phase_q == PH_VALUE) begin
						phase_d = PH_KEY;
					end else begin
						rem_d   = acc_or;
						phase_d = (acc_or == 64'd0) ? PH_KEY : PH_PAYLOAD;
					end
				end else begin
					acc_d = acc_or;
					sc_d  = sc_q + 4'd1;
				end
			end
			PH_FIXED, PH_PAYLOAD: begin
				rem_d = rem_dec;
				if (rem_dec == 64'd0) begin
					phase_d = PH_KEY;
				end
			end
			PH_DRAIN: begin
				phase_d = PH_DRAIN;
			end
			default: begin
				phase_d = PH_KEY;
			end
		endcase
	end

	// Results of the current byte.
	always_comb begin
		prim_v              = 1'b0;
		prim                = '0;
		prim.field_number   = fnum_q;
		prim.wire_type      = wt_q;
		unique case (phase_q)
			PH_KEY: begin
				if (too_long) begin
					prim_v            = 1'b1;
					prim.item_kind    = KIND_ERROR;
					prim.field_number = 32'd0;
					prim.wire_type    = 3'd0;
					prim.error_code   = ERR_TOO_LONG;
				end else if (!cont && key_wt_bad) begin
					prim_v            = 1'b1;
					prim.item_kind    = KIND_ERROR;
					prim.field_number = acc_or[34:3];
					prim.wire_type    = acc_or[2:0];
					prim.error_code   = ERR_WIRE_TYPE;
				end
			end
			PH_VALUE, PH_LENGTH: begin
				if (too_long) begin
					prim_v          = 1'b1;
					prim.item_kind  = KIND_ERROR;
					prim.error_code = ERR_TOO_LONG;
				end else if (!cont) begin
					prim_v           = 1'b1;
					prim.item_kind   = (phase_q == PH_VALUE) ? KIND_VARINT : KIND_LENGTH;
					prim.field_value = acc_or;
				end
			end
			PH_FIXED: begin
				if (rem_dec == 64'd0) begin
					prim_v         = 1'b1;
					prim.item_kind = KIND_FIXED;
				end
			end
			PH_PAYLOAD: begin
				prim_v             = 1'b1;
				prim.item_kind     = KIND_PAYLOAD;
				prim.payload_value = data_byte;
			end
			PH_DRAIN: begin
				prim_v = 1'b0;
			end
			default: begin
				prim_v = 1'b0;
			end
		endcase

		// A buffer that ends inside a field reports truncation.
		trunc            = '0;
		trunc.item_kind  = KIND_ERROR;
		trunc.error_code = ERR_TRUNCATED;
		if (phase_d == PH_KEY) begin
			trunc_v = buffer_last && (sc_d != 4'd0);
		end else begin
			trunc_v            = buffer_last && (phase_d != PH_DRAIN);
			trunc.field_number = fnum_d;
			trunc.wire_type    = wt_d;
		end

		// Pack into one queue entry; the last result carries the buffer end mark.
		entry = '0;
		if (prim_v) begin
			entry.r0    = prim;
			entry.r1    = trunc;
			entry.count = trunc_v ? 2'd2 : 2'd1;
		end else begin
			entry.r0    = trunc;
			entry.count = trunc_v ? 2'd1 : 2'd0;
		end
		if (buffer_last) begin
			if (entry.count == 2'd2) begin
				entry.r1.buffer_end = 1'b1;
			end else begin
				entry.r0.buffer_end = 1'b1;
			end
		end
	end

	assign push = fire && (entry.count != 2'd0);

	// Parser state; the buffer's final byte returns everything to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY;
			acc_q   <= 64'd0;
			sc_q    <= 4'd0;
			fnum_q  <= 32'd0;
			wt_q    <= 3'd0;
			rem_q   <= 64'd0;
		end else if (fire) begin
			if (buffer_last) begin
				phase_q <= PH_KEY;
				acc_q   <= 64'd0;
				sc_q    <= 4'd0;
				fnum_q  <= 32'd0;
				wt_q    <= 3'd0;
				rem_q   <= 64'd0;
			end else begin
				phase_q <= phase_d;
				acc_q   <= acc_d;
				sc_q    <= sc_d;
				fnum_q  <= fnum_d;
				wt_q    <= wt_d;
				rem_q   <= rem_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/pbwft_queue.sv =====
// ----------------------------------------------------------------------------
// Protobuf wire field tokenizer result queue
// A short first-in first-out queue of result entries between the parser
// front end and the output back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pbwft_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire pbwft_pkg::entry_t push_entry,
	output logic                   full,
	input  wire logic              pop,
	output logic                   not_empty,
	output pbwft_pkg::entry_t      head
);
	import pbwft_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/pbwft_back.sv =====
// ----------------------------------------------------------------------------
// Protobuf wire field tokenizer back end
// Takes queue entries apart into single results and holds each result in
// the output register until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pbwft_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              queue_valid,
	input  wire pbwft_pkg::entry_t head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pbwft_pkg::result_t     out_result
);
	import pbwft_pkg::*;

	logic    valid_q;
	logic    second_q;
	result_t result_q;
	logic    load;
	logic    last_of_entry;

	assign load          = queue_valid && (!valid_q || out_ready);
	assign last_of_entry = second_q || (head.count != 2'd2);
	assign pop           = load && last_of_entry;
	assign out_valid     = valid_q;
	assign out_result    = result_q;

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= second_q ? head.r1 : head.r0;
		end
	end

	// Output valid and the index of the next result within the head entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= !last_of_entry;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/protobuf_wire_field_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// Protobuf wire field tokenizer
// Splits a protobuf message buffer into field tokens, one byte per word.
// ----------------------------------------------------------------------------
// Usage: the slave side takes one buffer byte per word in s_tdata, with
// s_tlast on the buffer's final byte. The master side gives one token per
// word: kind in m_tuser, the token fields in m_tdata and m_tlast on the last
// token caused by the buffer's final byte.
// A byte is taken every cycle while the result queue has room. Each byte
// yields zero, one or two tokens; the back end sends one token per cycle
// while m_tready is high, so the tokens of one byte leave one after another.
// A token passes through the queue, written when its byte is accepted, and
// then the output register, which loads it from the queue head and drives
// m_tvalid. The parser keeps the varint, key and length state and handles
// every byte as it is accepted; the output register sets the token rate.
// Reset clears the parser to the key phase and empties the queue and the
// output register. When the receiver stalls, the held token stays put, the
// queue fills and s_tready falls once QUEUE_DEPTH entries wait.
// ----------------------------------------------------------------------------
`default_nettype none

module protobuf_wire_field_tokenizer_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
	input  wire logic         s_tlast,   // buffer_last
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [111:0]      m_tdata,   // [31:0] field_number, [34:32] wire_type,
	                                     // [98:35] field_value, [106:99] payload_value,
	                                     // [108:107] error_code, [111:109] zero
	output logic [2:0]        m_tuser,   // [2:0] item_kind
	output logic              m_tlast    // buffer_end
);
	import pbwft_pkg::*;

	logic    push;
	entry_t  push_entry;
	logic    full;
	logic    pop;
	logic    not_empty;
	entry_t  head;
	result_t res;

	// Parser front end.
	pbwft_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.data_byte   (s_tdata),
		.buffer_last (s_tlast),
		.queue_full  (full),
		.push        (push),
		.entry       (push_entry)
	);

	// Queue between the two halves.
	pbwft_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	// Output back end.
	pbwft_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_valid (not_empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_result  (res)
	);

	// Pack the token onto the master side.
	assign m_tdata = {3'b000, res.error_code, res.payload_value, res.field_value,
		res.wire_type, res.field_number};
	assign m_tuser = res.item_kind;
	assign m_tlast = res.buffer_end;

endmodule

`default_nettype wire

// ===== dv/protobuf_wire_field_tokenizer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Protobuf wire field tokenizer testbench
// Feeds message buffers one byte per word and checks every token against a
// cycle-free model of the tokenizer or a typed row. A short directed table
// covers the error codes, the empty payload and the extremes. Random buffers
// follow: mostly well-formed fields with random content, plus bad keys,
// overlong varints, noise and cut-off buffers. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module protobuf_wire_field_tokenizer_top_tb;

	import pbwft_pkg::*;

	// Return codes of the varint byte absorber.
	localparam int VI_MORE = 0;
	localparam int VI_DONE = 1;
	localparam int VI_LONG = 2;

	// Wire type with no meaning in the format.
	localparam logic [2:0] WIRE_RESERVED7 = 3'd7;

	// Receiver hold-off length in cycles.
	localparam int HOLD_CYCLES = 400;

	// One row of the directed table.
	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         typed;
		int         cnt;
		result_t    r0;
		result_t    r1;
	} stim_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'h00;   // [7:0] data_byte
	logic         s_tlast = 1'b0;    // buffer_last
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [111:0] m_tdata;           // [31:0] field_number, [34:32] wire_type,
	                                 // [98:35] field_value, [106:99] payload_value,
	                                 // [108:107] error_code, [111:109] zero
	logic [2:0]   m_tuser;           // [2:0] item_kind
	logic         m_tlast;           // buffer_end

	// Model state of the tokenizer.
	phase_t      tk_phase;
	logic [63:0] tk_acc;
	logic [3:0]  tk_nbytes;
	logic [31:0] tk_field;
	logic [2:0]  tk_wtype;
	logic [63:0] tk_left;

	// Tokens caused by the byte just modeled.
	result_t step_out [2];
	int      step_n;

	// Tokens waiting for the output side.
	result_t token_q [$];

	stim_row_t  dir_rows [$];
	logic [7:0] msg_q [$];

	int err_cnt = 0;
	int sent_cnt = 0;
	int tx_idle = 0;
	int rx_idle = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;

	protobuf_wire_field_tokenizer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit.
	initial begin
		#2000000;
		$display("protobuf_wire_field_tokenizer_top_tb NOT OK");
		$finish;
	end

	function automatic result_t make_token(input logic [2:0] kind, input logic [31:0] fn,
			input logic [2:0] wt, input logic [63:0] fv, input logic [7:0] pv,
			input logic [1:0] ec, input logic be);
		result_t r;
		r.item_kind     = kind;
		r.field_number  = fn;
		r.wire_type     = wt;
		r.field_value   = fv;
		r.payload_value = pv;
		r.error_code    = ec;
		r.buffer_end    = be;
		return r;
	endfunction

	function automatic void emit_token(input logic [2:0] kind, input logic [31:0] fn,
			input logic [2:0] wt, input logic [63:0] fv, input logic [7:0] pv,
			input logic [1:0] ec);
		step_out[step_n] = make_token(kind, fn, wt, fv, pv, ec, 1'b0);
		step_n++;
	endfunction

	function automatic void clear_tokenizer();
		tk_phase  = PH_KEY;
		tk_acc    = 64'd0;
		tk_nbytes = 4'd0;
		tk_field  = 32'd0;
		tk_wtype  = 3'd0;
		tk_left   = 64'd0;
	endfunction

	// Adds the low seven bits of a varint byte at the current position.
	function automatic int take_varint_byte(input logic [7:0] b);
		tk_acc = tk_acc | ({57'd0, b[6:0]} << (7 * int'(tk_nbytes)));
		if (!b[7])
			return VI_DONE;
		tk_nbytes = tk_nbytes + 4'd1;
		if (tk_nbytes > VARINT_LAST_IDX)
			return VI_LONG;
		return VI_MORE;
	endfunction

	// Advances the model by one buffer byte and collects its tokens.
	function automatic void tokenize_byte(input logic [7:0] b, input logic last);
		int v;
		step_n = 0;
		case (tk_phase)
			PH_KEY: begin
				v = take_varint_byte(b);
				if (v == VI_LONG) begin
					emit_token(KIND_ERROR, 32'd0, WIRE_VARINT, 64'd0, 8'd0, ERR_TOO_LONG);
					tk_phase = PH_DRAIN;
				end else if (v == VI_DONE) begin
					tk_field  = tk_acc[34:3];
					tk_wtype  = tk_acc[2:0];
					tk_acc    = 64'd0;
					tk_nbytes = 4'd0;
					case (tk_wtype)
						WIRE_VARINT: tk_phase = PH_VALUE;
						WIRE_FIXED64: begin
							tk_phase = PH_FIXED;
							tk_left  = 64'd8;
						end
						WIRE_FIXED32: begin
							tk_phase = PH_FIXED;
							tk_left  = 64'd4;
						end
						WIRE_LENGTH: tk_phase = PH_LENGTH;
						default: begin
							emit_token(KIND_ERROR, tk_field, tk_wtype, 64'd0, 8'd0,
								ERR_WIRE_TYPE);
							tk_phase = PH_DRAIN;
						end
					endcase
				end
			end
			PH_VALUE: begin
				v = take_varint_byte(b);
				if (v == VI_LONG) begin
					emit_token(KIND_ERROR, tk_field, tk_wtype, 64'd0, 8'd0, ERR_TOO_LONG);
					tk_phase = PH_DRAIN;
				end else if (v == VI_DONE) begin
					emit_token(KIND_VARINT, tk_field, tk_wtype, tk_acc, 8'd0, 2'd0);
					tk_acc    = 64'd0;
					tk_nbytes = 4'd0;
					tk_phase  = PH_KEY;
				end
			end
			PH_FIXED: begin
				if (tk_left != 0)
					tk_left = tk_left - 64'd1;
				if (tk_left == 0) begin
					emit_token(KIND_FIXED, tk_field, tk_wtype, 64'd0, 8'd0, 2'd0);
					tk_phase = PH_KEY;
				end
			end
			PH_LENGTH: begin
				v = take_varint_byte(b);
				if (v == VI_LONG) begin
					emit_token(KIND_ERROR, tk_field, tk_wtype, 64'd0, 8'd0, ERR_TOO_LONG);
					tk_phase = PH_DRAIN;
				end else if (v == VI_DONE) begin
					emit_token(KIND_LENGTH, tk_field, tk_wtype, tk_acc, 8'd0, 2'd0);
					tk_left   = tk_acc;
					tk_acc    = 64'd0;
					tk_nbytes = 4'd0;
					tk_phase  = (tk_left == 0) ? PH_KEY : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				emit_token(KIND_PAYLOAD, tk_field, tk_wtype, 64'd0, b, 2'd0);
				if (tk_left != 0)
					tk_left = tk_left - 64'd1;
				if (tk_left == 0)
					tk_phase = PH_KEY;
			end
			default: begin
				// Bytes after an error are dropped up to the buffer's end.
			end
		endcase

		// The final byte flags an unfinished field and clears all state.
		if (last) begin
			if (tk_phase == PH_KEY) begin
				if (tk_nbytes != 0)
					emit_token(KIND_ERROR, 32'd0, WIRE_VARINT, 64'd0, 8'd0, ERR_TRUNCATED);
			end else if (tk_phase != PH_DRAIN) begin
				emit_token(KIND_ERROR, tk_field, tk_wtype, 64'd0, 8'd0, ERR_TRUNCATED);
			end
			if (step_n > 0)
				step_out[step_n - 1].buffer_end = 1'b1;
			clear_tokenizer();
		end
	endfunction

	function automatic void row_predicted(input logic [7:0] d, input logic l);
		stim_row_t r;
		r.data  = d;
		r.last  = l;
		r.typed = 1'b0;
		r.cnt   = 0;
		r.r0    = '0;
		r.r1    = '0;
		dir_rows = {dir_rows, r};
	endfunction

	function automatic void row_typed(input logic [7:0] d, input logic l, input int cnt,
			input result_t r0);
		stim_row_t r;
		r.data  = d;
		r.last  = l;
		r.typed = 1'b1;
		r.cnt   = cnt;
		r.r0    = r0;
		r.r1    = '0;
		dir_rows = {dir_rows, r};
	endfunction

	// Appends a varint, padded with redundant bytes up to min_len.
	function automatic void put_varint(input logic [63:0] val, input int min_len);
		logic [7:0]  b;
		logic [63:0] v;
		int          n;
		v = val;
		n = 0;
		do begin
			b = {1'b0, v[6:0]};
			v = v >> 7;
			n++;
			if (v != 0 || n < min_len)
				b[7] = 1'b1;
			msg_q = {msg_q, b};
		end while (v != 0 || n < min_len);
	endfunction

	function automatic logic [63:0] rand_wide();
		logic [63:0] v;
		v = {$urandom, $urandom};
		if ($urandom_range(15) == 0)
			return '1;
		return v >> $urandom_range(63);
	endfunction

	function automatic int pad_len();
		return ($urandom_range(7) == 0) ? $urandom_range(10, 1) : 1;
	endfunction

	function automatic void put_key(input logic [2:0] wt);
		logic [63:0] fn;
		case ($urandom_range(3))
			0: fn = 64'($urandom_range(15, 1));
			1: fn = 64'($urandom_range(65535));
			2: fn = 64'($urandom);
			default: fn = rand_wide() >> 3;
		endcase
		put_varint({fn[60:0], wt}, pad_len());
	endfunction

	// Builds one random message buffer in msg_q.
	function automatic void build_message();
		int          nf;
		int          sel;
		int          plen;
		logic [2:0]  bad_wt [4];
		bad_wt = '{3'd3, 3'd4, 3'd6, WIRE_RESERVED7};
		msg_q.delete();
		nf = $urandom_range(6, 1);
		for (int i = 0; i < nf; i++) begin
			sel = $urandom_range(99);
			if (sel < 22) begin
				put_key(WIRE_VARINT);
				put_varint(rand_wide(), pad_len());
			end else if (sel < 38) begin
				put_key(WIRE_FIXED64);
				repeat (8) msg_q = {msg_q, 8'($urandom_range(255))};
			end else if (sel < 54) begin
				put_key(WIRE_FIXED32);
				repeat (4) msg_q = {msg_q, 8'($urandom_range(255))};
			end else if (sel < 86) begin
				put_key(WIRE_LENGTH);
				plen = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
				put_varint(64'(plen), pad_len());
				repeat (plen) msg_q = {msg_q, 8'($urandom_range(255))};
			end else if (sel < 92) begin
				put_key(bad_wt[$urandom_range(3)]);
			end else if (sel < 96) begin
				// Overlong varint, in the key or in a value.
				if ($urandom_range(1))
					put_key(WIRE_VARINT);
				repeat (10) msg_q = {msg_q, 8'($urandom_range(255)) | 8'h80};
			end else begin
				repeat ($urandom_range(4, 1)) msg_q = {msg_q, 8'($urandom_range(255))};
			end
		end
		// Sometimes the buffer is cut off inside a field.
		if ($urandom_range(7) == 0 && msg_q.size() > 1)
			msg_q = msg_q[0:$urandom_range(msg_q.size() - 2)];
	endfunction

	// Offers one byte, waits for its acceptance and records its tokens.
	task automatic send_byte(input logic [7:0] d, input logic l, input bit typed,
			input int tcnt, input result_t t0, input result_t t1);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tokenize_byte(d, l);
		if (typed) begin
			if (tcnt > 0)
				token_q = {token_q, t0};
			if (tcnt > 1)
				token_q = {token_q, t1};
		end else begin
			for (int i = 0; i < step_n; i++)
				token_q = {token_q, step_out[i]};
		end
		sent_cnt++;
	endtask

	task automatic send_messages(input int target);
		sent_cnt = 0;
		while (sent_cnt < target) begin
			build_message();
			foreach (msg_q[i])
				send_byte(msg_q[i], (i == msg_q.size() - 1), 1'b0, 0, '0, '0);
		end
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (token_q.size() != 0);
	endtask

	// Receiver: random stalls, and a long hold-off when one is asked for.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			err_cnt++;
		end
	endtask

	// Output checker: each token word against the oldest expectation.
	always @(posedge clk) begin
		result_t ex;
		if (arst_n && m_tvalid && m_tready) begin
			if (token_q.size() == 0) begin
				$error("unexpected token word: kind %0h data %0h", m_tuser, m_tdata);
				err_cnt++;
			end else begin
				ex = token_q.pop_front();
				check_field("item_kind", 64'(ex.item_kind), 64'(m_tuser));
				check_field("field_number", 64'(ex.field_number), 64'(m_tdata[31:0]));
				check_field("wire_type", 64'(ex.wire_type), 64'(m_tdata[34:32]));
				check_field("field_value", ex.field_value, m_tdata[98:35]);
				check_field("payload_value", 64'(ex.payload_value), 64'(m_tdata[106:99]));
				check_field("error_code", 64'(ex.error_code), 64'(m_tdata[108:107]));
				check_field("buffer_end", 64'(ex.buffer_end), 64'(m_tlast));
			end
		end
	end

	// Stimulus sequence.
	initial begin
		clear_tokenizer();

		// Varint 150, empty payload, two-byte payload ending the buffer.
		row_predicted(8'h08, 1'b0);
		row_predicted(8'h96, 1'b0);
		row_predicted(8'h01, 1'b0);
		row_predicted(8'h22, 1'b0);
		row_predicted(8'h00, 1'b0);
		row_predicted(8'h1a, 1'b0);
		row_predicted(8'h02, 1'b0);
		row_predicted(8'hff, 1'b0);
		row_predicted(8'h00, 1'b1);
		// Bad wire type, then the final byte is dropped.
		row_typed(8'h0f, 1'b0, 1,
			make_token(KIND_ERROR, 32'd1, WIRE_RESERVED7, 64'd0, 8'd0, ERR_WIRE_TYPE, 1'b0));
		row_typed(8'haa, 1'b1, 0, '0);
		// Fixed 64-bit field cut off after one byte.
		row_predicted(8'h09, 1'b0);
		row_typed(8'h01, 1'b1, 1,
			make_token(KIND_ERROR, 32'd1, WIRE_FIXED64, 64'd0, 8'd0, ERR_TRUNCATED, 1'b1));
		// Key varint that never ends within ten bytes.
		repeat (9) row_predicted(8'hff, 1'b0);
		row_typed(8'hff, 1'b1, 1,
			make_token(KIND_ERROR, 32'd0, WIRE_VARINT, 64'd0, 8'd0, ERR_TOO_LONG, 1'b1));
		// Buffer ending inside the key.
		row_typed(8'h80, 1'b1, 1,
			make_token(KIND_ERROR, 32'd0, WIRE_VARINT, 64'd0, 8'd0, ERR_TRUNCATED, 1'b1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 19;
		rx_idle <= 82;
		foreach (dir_rows[i])
			send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed,
				dir_rows[i].cnt, dir_rows[i].r0, dir_rows[i].r1);
		send_messages(370);

		// Sender pauses until every token is out.
		s_tvalid <= 1'b0;
		wait_drained();

		tx_idle = 82;
		rx_idle <= 19;
		send_messages(370);

		// Receiver holds off while the sender keeps offering bytes.
		tx_idle = 0;
		rx_idle <= 0;
		hold_asked <= hold_asked + 1;
		send_messages(60);
		send_messages(310);

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (err_cnt == 0 && token_q.size() == 0)
			$display("protobuf_wire_field_tokenizer_top_tb OK");
		else
			$display("protobuf_wire_field_tokenizer_top_tb NOT OK");
		$finish;
	end

endmodule

// ===== protobuf_wire_field_tokenizer_top.f =====
design/pbwft_pkg.sv
design/pbwft_front.sv
design/pbwft_queue.sv
design/pbwft_back.sv
design/protobuf_wire_field_tokenizer_top.sv
dv/protobuf_wire_field_tokenizer_top_tb.sv
